/* rtl/core/mttb_pkg.sv */
// Package for the timer tick bank: beat payload types, action and bank codes,
// and the command/status structs between controller and datapath.
// Depends on nothing.
package mttb_pkg;

   // Field widths
   localparam int ACTION_W  = 3;
   localparam int GROUP_W   = 2;
   localparam int INDEX_W   = 6;
   localparam int IDXCMP_W  = INDEX_W + 1;
   localparam int VALUE_W   = 10;
   localparam int COUNT_W   = 11;
   localparam int SEC_SET_W = 8;
   localparam int SEC_CNT_W = 9;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_BASE_TICK = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SEC_TICK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE     = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd4;

   // Bank codes
   localparam logic [GROUP_W-1:0] GRP_AUTO = 2'd0;
   localparam logic [GROUP_W-1:0] GRP_DOWN = 2'd1;
   localparam logic [GROUP_W-1:0] GRP_SEC  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [GROUP_W-1:0]  group;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  value_in;
      logic                enable_in;
      logic                auto_in;
      logic                clear_flag;
   } req_type;

   typedef struct packed {
      logic               end_flag;
      logic               enabled;
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] set_time;
      logic               any_end;
      logic               bad_index;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // take the request beat, set up the pointer
      logic step;   // update the entry under the pointer, advance it
      logic exec;   // carry out the operation and load the result beat
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic new_tick;   // incoming beat is a tick
      logic walk_last;  // pointer is on the last entry of the walk
   } status_type;

endpackage

/* rtl/core/mttb_ctrl.sv */
// Controller for the timer tick bank: sequences accept, bank walk and result.
// Depends on mttb_pkg.
module mttb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mttb_pkg::status_type   status,
   output mttb_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Result slot can take a new beat when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.new_tick ? ST_WALK : ST_EXEC;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is only loaded into a free slot
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> slot_free)
      else $error("result loaded over an undelivered beat");

   // Loading a result always presents it next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("result beat lost after load");

   // Walk carries on until the last entry is reached
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !status.walk_last) |=> (state_ff == ST_WALK))
      else $error("walk left early");

endmodule

/* rtl/core/mttb_datapath.sv */
// Datapath for the timer tick bank: timer entry registers, walk pointer,
// end flag counter and result register. Depends on mttb_pkg.
module mttb_datapath #(
   parameter int AUTO_TIMERS   = 8,
   parameter int DOWN_TIMERS   = 8,
   parameter int SECOND_TIMERS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mttb_pkg::req_type     req_data,
   input  mttb_pkg::cmd_type     cmd,
   output mttb_pkg::status_type  status,
   output mttb_pkg::rsp_type     rsp_data
);

   localparam int AAW       = (AUTO_TIMERS > 1) ? $clog2(AUTO_TIMERS) : 1;
   localparam int DAW       = (DOWN_TIMERS > 1) ? $clog2(DOWN_TIMERS) : 1;
   localparam int SAW       = (SECOND_TIMERS > 1) ? $clog2(SECOND_TIMERS) : 1;
   localparam int BASE_WALK = (AUTO_TIMERS > DOWN_TIMERS) ? AUTO_TIMERS : DOWN_TIMERS;
   localparam int ALL_TIMERS = AUTO_TIMERS + DOWN_TIMERS + SECOND_TIMERS;
   localparam int ECW       = $clog2(ALL_TIMERS + 1);

   typedef struct packed {
      logic [mttb_pkg::VALUE_W-1:0] set_time;
      logic [mttb_pkg::COUNT_W-1:0] count;
      logic                         enable;
      logic                         end_flag;
   } auto_entry_type;

   typedef struct packed {
      logic [mttb_pkg::VALUE_W-1:0] count;
      logic                         enable;
      logic                         end_flag;
   } down_entry_type;

   typedef struct packed {
      logic [mttb_pkg::SEC_SET_W-1:0] set_time;
      logic [mttb_pkg::SEC_CNT_W-1:0] count;
      logic                           enable;
      logic                           auto_mode;
      logic                           end_flag;
   } sec_entry_type;

   mttb_pkg::req_type           req_ff;
   logic [mttb_pkg::INDEX_W-1:0] ptr_ff, ptr_in;
   logic [ECW-1:0]              end_cnt_ff, end_cnt_in;
   mttb_pkg::rsp_type           rsp_ff, rsp_in;

   auto_entry_type auto_ff [AUTO_TIMERS];
   down_entry_type down_ff [DOWN_TIMERS];
   sec_entry_type  sec_ff  [SECOND_TIMERS];

   auto_entry_type auto_cur, auto_in;
   down_entry_type down_cur, down_in;
   sec_entry_type  sec_cur, sec_in;
   logic           auto_we, down_we, sec_we;
   logic           auto_set_end, down_set_end, sec_set_end, end_cleared;

   logic [AAW-1:0] aptr;
   logic [DAW-1:0] dptr;
   logic [SAW-1:0] sptr;
   logic [mttb_pkg::IDXCMP_W-1:0] ptr_ext;
   logic in_auto, in_down, in_sec;
   logic entry_ok, is_write, is_read, clear_all;
   logic base_walk, sec_walk;
   logic [mttb_pkg::COUNT_W-1:0]   auto_inc;
   logic [mttb_pkg::SEC_CNT_W-1:0] sec_inc;
   logic [ALL_TIMERS-1:0] end_vec;

   // Pointer views into each bank and range checks
   assign aptr    = ptr_ff[AAW-1:0];
   assign dptr    = ptr_ff[DAW-1:0];
   assign sptr    = ptr_ff[SAW-1:0];
   assign ptr_ext = {1'b0, ptr_ff};
   assign in_auto = ptr_ext < mttb_pkg::IDXCMP_W'(AUTO_TIMERS);
   assign in_down = ptr_ext < mttb_pkg::IDXCMP_W'(DOWN_TIMERS);
   assign in_sec  = ptr_ext < mttb_pkg::IDXCMP_W'(SECOND_TIMERS);

   assign auto_cur = in_auto ? auto_ff[aptr] : '0;
   assign down_cur = in_down ? down_ff[dptr] : '0;
   assign sec_cur  = in_sec  ? sec_ff[sptr]  : '0;

   // Entry under the latched request; the pointer holds its index
   always_comb begin
      case (req_ff.group)
         mttb_pkg::GRP_AUTO: entry_ok = in_auto;
         mttb_pkg::GRP_DOWN: entry_ok = in_down;
         mttb_pkg::GRP_SEC:  entry_ok = in_sec;
         default:            entry_ok = 1'b0;
      endcase
   end

   assign is_write  = cmd.exec && (req_ff.action == mttb_pkg::ACT_WRITE) && entry_ok;
   assign is_read   = cmd.exec && (req_ff.action == mttb_pkg::ACT_READ) && entry_ok;
   assign clear_all = cmd.exec && (req_ff.action == mttb_pkg::ACT_CLEAR);
   assign base_walk = cmd.step && (req_ff.action == mttb_pkg::ACT_BASE_TICK);
   assign sec_walk  = cmd.step && (req_ff.action == mttb_pkg::ACT_SEC_TICK);

   assign auto_inc = auto_cur.count + mttb_pkg::COUNT_W'(1);
   assign sec_inc  = sec_cur.count + mttb_pkg::SEC_CNT_W'(1);

   // Auto-reload bank entry update
   always_comb begin
      auto_in      = auto_cur;
      auto_we      = 1'b0;
      auto_set_end = 1'b0;
      if (base_walk && in_auto) begin
         auto_we = 1'b1;
         if (auto_cur.enable) begin
            if (auto_inc > {1'b0, auto_cur.set_time}) begin
               auto_in.count    = '0;
               auto_in.end_flag = 1'b1;
               auto_set_end     = !auto_cur.end_flag;
            end else begin
               auto_in.count = auto_inc;
            end
         end else begin
            auto_in.count = '0;
         end
      end else if (is_write && req_ff.group == mttb_pkg::GRP_AUTO) begin
         auto_we          = 1'b1;
         auto_in.set_time = req_ff.value_in;
         auto_in.enable   = req_ff.enable_in;
         auto_in.count    = '0;
      end else if (is_read && req_ff.group == mttb_pkg::GRP_AUTO && req_ff.clear_flag) begin
         auto_we          = 1'b1;
         auto_in.end_flag = 1'b0;
      end
   end

   // One-shot down bank entry update
   always_comb begin
      down_in      = down_cur;
      down_we      = 1'b0;
      down_set_end = 1'b0;
      if (base_walk && in_down) begin
         down_we = 1'b1;
         if (down_cur.enable) begin
            if (down_cur.count != '0) begin
               down_in.count = down_cur.count - mttb_pkg::VALUE_W'(1);
            end else begin
               down_in.enable   = 1'b0;
               down_in.end_flag = 1'b1;
               down_set_end     = !down_cur.end_flag;
            end
         end else begin
            down_in.count = '0;
         end
      end else if (is_write && req_ff.group == mttb_pkg::GRP_DOWN) begin
         down_we        = 1'b1;
         down_in.count  = req_ff.value_in;
         down_in.enable = req_ff.enable_in;
      end else if (is_read && req_ff.group == mttb_pkg::GRP_DOWN && req_ff.clear_flag) begin
         down_we          = 1'b1;
         down_in.end_flag = 1'b0;
      end
   end

   // Seconds bank entry update
   always_comb begin
      sec_in      = sec_cur;
      sec_we      = 1'b0;
      sec_set_end = 1'b0;
      if (sec_walk && in_sec) begin
         sec_we = 1'b1;
         if (sec_cur.enable) begin
            if (sec_inc > {1'b0, sec_cur.set_time}) begin
               sec_in.count    = '0;
               sec_in.end_flag = 1'b1;
               sec_in.enable   = sec_cur.auto_mode;
               sec_set_end     = !sec_cur.end_flag;
            end else begin
               sec_in.count = sec_inc;
            end
         end else begin
            sec_in.count = '0;
         end
      end else if (is_write && req_ff.group == mttb_pkg::GRP_SEC) begin
         sec_we           = 1'b1;
         sec_in.set_time  = req_ff.value_in[mttb_pkg::SEC_SET_W-1:0];
         sec_in.enable    = req_ff.enable_in;
         sec_in.auto_mode = req_ff.auto_in;
         sec_in.count     = '0;
      end else if (is_read && req_ff.group == mttb_pkg::GRP_SEC && req_ff.clear_flag) begin
         sec_we          = 1'b1;
         sec_in.end_flag = 1'b0;
      end
   end

   // Read side: flag reported before any clear
   always_comb begin
      rsp_in           = '0;
      end_cleared      = 1'b0;
      rsp_in.bad_index = ((req_ff.action == mttb_pkg::ACT_WRITE) ||
                          (req_ff.action == mttb_pkg::ACT_READ)) && !entry_ok;
      if (req_ff.action == mttb_pkg::ACT_READ && entry_ok) begin
         case (req_ff.group)
            mttb_pkg::GRP_AUTO: begin
               rsp_in.end_flag = auto_cur.end_flag;
               rsp_in.enabled  = auto_cur.enable;
               rsp_in.count    = auto_cur.count;
               rsp_in.set_time = auto_cur.set_time;
            end
            mttb_pkg::GRP_DOWN: begin
               rsp_in.end_flag = down_cur.end_flag;
               rsp_in.enabled  = down_cur.enable;
               rsp_in.count    = mttb_pkg::COUNT_W'(down_cur.count);
            end
            default: begin
               rsp_in.end_flag = sec_cur.end_flag;
               rsp_in.enabled  = sec_cur.enable;
               rsp_in.count    = mttb_pkg::COUNT_W'(sec_cur.count);
               rsp_in.set_time = mttb_pkg::VALUE_W'(sec_cur.set_time);
            end
         endcase
         end_cleared = is_read && req_ff.clear_flag && rsp_in.end_flag;
      end
      rsp_in.any_end = (end_cnt_in != '0);
   end

   // Running count of set end flags; at most one change per bank a cycle
   always_comb begin
      if (clear_all) begin
         end_cnt_in = '0;
      end else begin
         end_cnt_in = end_cnt_ff + ECW'(auto_set_end) + ECW'(down_set_end)
                      + ECW'(sec_set_end) - ECW'(end_cleared);
      end
   end

   // Pointer: request index for access, zero for a walk
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = status.new_tick ? '0 : req_data.index;
      end else if (cmd.step) begin
         ptr_in = ptr_ff + mttb_pkg::INDEX_W'(1);
      end
   end

   assign status.new_tick  = (req_data.action == mttb_pkg::ACT_BASE_TICK) ||
                             (req_data.action == mttb_pkg::ACT_SEC_TICK);
   assign status.walk_last = (req_ff.action == mttb_pkg::ACT_SEC_TICK) ?
                             (ptr_ff == mttb_pkg::INDEX_W'(SECOND_TIMERS - 1)) :
                             (ptr_ff == mttb_pkg::INDEX_W'(BASE_WALK - 1));

   // Request and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         end_cnt_ff <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         end_cnt_ff <= end_cnt_in;
      end
   end

   // Timer entries
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int k = 0; k < AUTO_TIMERS; k++) begin
            auto_ff[k] <= '0;
         end
         for (int k = 0; k < DOWN_TIMERS; k++) begin
            down_ff[k] <= '0;
         end
         for (int k = 0; k < SECOND_TIMERS; k++) begin
            sec_ff[k] <= '0;
         end
      end else begin
         if (auto_we) begin
            auto_ff[aptr] <= auto_in;
         end
         if (down_we) begin
            down_ff[dptr] <= down_in;
         end
         if (sec_we) begin
            sec_ff[sptr] <= sec_in;
         end
      end
   end

   // Flat view of all end flags for checking the counter
   always_comb begin
      for (int k = 0; k < AUTO_TIMERS; k++) begin
         end_vec[k] = auto_ff[k].end_flag;
      end
      for (int k = 0; k < DOWN_TIMERS; k++) begin
         end_vec[AUTO_TIMERS + k] = down_ff[k].end_flag;
      end
      for (int k = 0; k < SECOND_TIMERS; k++) begin
         end_vec[AUTO_TIMERS + DOWN_TIMERS + k] = sec_ff[k].end_flag;
      end
   end

   // Counter tracks the end flags exactly
   assert property (@(posedge clock) disable iff (reset)
      end_cnt_ff == ECW'($countones(end_vec)))
      else $error("end flag counter out of step with entries");

   // A walk never writes beyond the last entry of its banks
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (ptr_ext < mttb_pkg::IDXCMP_W'(BASE_WALK) ||
                    ptr_ext < mttb_pkg::IDXCMP_W'(SECOND_TIMERS)))
      else $error("walk pointer out of range");

endmodule

/* rtl/core/multi_timer_tick_bank.sv */
// Top level of the timer tick bank: controller plus datapath.
// Depends on mttb_pkg, mttb_ctrl and mttb_datapath.
//
//  channel  | direction | signals                         | payload
//  ---------+-----------+---------------------------------+----------------------
//  request  | in        | req_valid, req_ready, req_data  | mttb_pkg::req_type
//  response | out       | rsp_valid, rsp_ready, rsp_data  | mttb_pkg::rsp_type
//
// One request beat in gives exactly one response beat out; one beat at a time.
// Base tick: walks max(AUTO_TIMERS, DOWN_TIMERS) entries; seconds tick walks
// SECOND_TIMERS entries; the walk updates one entry per bank each cycle.
// Write, read, clear all and unknown actions go from accept straight to the result.
// A pending response beat does not block the next request; the result stage
// waits only when the previous beat is still not taken.
// Synchronous active-high reset clears every timer entry.
module multi_timer_tick_bank #(
   parameter int AUTO_TIMERS   = 8,
   parameter int DOWN_TIMERS   = 8,
   parameter int SECOND_TIMERS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mttb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mttb_pkg::rsp_type rsp_data
);

   mttb_pkg::cmd_type    cmd;
   mttb_pkg::status_type status;

   mttb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mttb_datapath #(
      .AUTO_TIMERS   (AUTO_TIMERS),
      .DOWN_TIMERS   (DOWN_TIMERS),
      .SECOND_TIMERS (SECOND_TIMERS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
